@@ sv/ppmfd_pkg.sv @@
// ----------------------------------------------------------------------------
// PPM frame decoder package
// Shared types, register codes, result codes and reset values.
// ----------------------------------------------------------------------------
package ppmfd_pkg;

    localparam int NUM_CHANNELS_DEF = 8;
    localparam int QUEUE_DEPTH      = 4;

    localparam logic [15:0] SYNC_GAP_MIN_RST = 16'd2200;
    localparam logic [15:0] PULSE_MIN_RST    = 16'd900;
    localparam logic [15:0] PULSE_MAX_RST    = 16'd2100;

    typedef enum logic [1:0] {
        REG_SYNC_GAP_MIN = 2'd0,
        REG_PULSE_MIN    = 2'd1,
        REG_PULSE_MAX    = 2'd2
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_WAITING    = 3'd0,
        ST_ACQUIRED   = 3'd1,
        ST_FRAME_SYNC = 3'd2,
        ST_STORED     = 3'd3,
        ST_FRAME_CH   = 3'd4,
        ST_LOST       = 3'd5
    } status_t;

    typedef struct packed {
        logic [15:0] sync_gap_min;
        logic [15:0] pulse_min;
        logic [15:0] pulse_max;
    } cfg_t;

    typedef struct packed {
        logic [15:0] pulse_width_us;
        logic        frame_flag;
        logic [2:0]  channel_index;
        status_t     status;
    } q_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

@@ sv/ppmfd_queue.sv @@
// ----------------------------------------------------------------------------
// PPM frame decoder command queue
// Small FIFO of classified words between the front and the back.
// ----------------------------------------------------------------------------
module ppmfd_queue #(
    parameter int DEPTH = ppmfd_pkg::QUEUE_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  ppmfd_pkg::q_entry_t  push_entry,
    input  logic                 pop,
    output ppmfd_pkg::q_entry_t  pop_entry,
    output ppmfd_pkg::q_status_t stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ppmfd_pkg::q_entry_t mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign pop_entry  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

@@ sv/ppmfd_front.sv @@
// ----------------------------------------------------------------------------
// PPM frame decoder front
// Measure edge gaps, track sync and channel count, store channels, classify.
// ----------------------------------------------------------------------------
module ppmfd_front #(
    parameter int NUM_CHANNELS = ppmfd_pkg::NUM_CHANNELS_DEF,
    parameter int IDX_W        = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ppmfd_pkg::cfg_t      cfg,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [15:0]          edge_time_lo,
    output logic                 push,
    output ppmfd_pkg::q_entry_t  push_entry,
    input  ppmfd_pkg::q_status_t q_stat,
    input  logic                 frame_done,
    input  logic [IDX_W-1:0]     rd_idx,
    output logic [15:0]          rd_data
);

    logic [15:0]      prev_time_reg;
    logic             synced_reg, synced_next;
    logic [IDX_W-1:0] count_reg, count_next;
    logic             flag_reg, flag_next;
    logic             frame_pend_reg, frame_pend_next;
    logic [15:0]      store_reg [NUM_CHANNELS];

    logic [15:0] gap;
    logic        is_sync;
    logic        in_window;
    logic        accept;
    logic        store_wr;

    assign in_ready  = !frame_pend_reg && !q_stat.full;
    assign accept    = in_valid && in_ready;
    assign push      = accept;
    assign gap       = edge_time_lo - prev_time_reg;
    assign is_sync   = (gap >= cfg.sync_gap_min);
    assign in_window = (gap >= cfg.pulse_min) && (gap <= cfg.pulse_max);
    assign rd_data   = store_reg[rd_idx];

    always_comb
    begin
        synced_next     = synced_reg;
        count_next      = count_reg;
        flag_next       = flag_reg;
        frame_pend_next = frame_pend_reg && !frame_done;
        store_wr        = 1'b0;
        push_entry.status         = ppmfd_pkg::ST_WAITING;
        push_entry.channel_index  = '0;
        push_entry.pulse_width_us = gap;
        if (accept)
        begin
            priority if (!synced_reg)
            begin
                if (is_sync)
                begin
                    synced_next       = 1'b1;
                    count_next        = '0;
                    flag_next         = 1'b0;
                    push_entry.status = ppmfd_pkg::ST_ACQUIRED;
                end
            end
            else if (is_sync)
            begin
                count_next        = '0;
                flag_next         = 1'b1;
                push_entry.status = ppmfd_pkg::ST_FRAME_SYNC;
            end
            else if (in_window)
            begin
                store_wr = 1'b1;
                if (count_reg == IDX_W'(NUM_CHANNELS - 1))
                begin
                    count_next        = '0;
                    frame_pend_next   = 1'b1;
                    push_entry.status = ppmfd_pkg::ST_FRAME_CH;
                end
                else
                begin
                    count_next               = count_reg + 1'b1;
                    push_entry.status        = ppmfd_pkg::ST_STORED;
                    push_entry.channel_index = 3'(count_reg);
                end
            end
            else
            begin
                synced_next       = 1'b0;
                push_entry.status = ppmfd_pkg::ST_LOST;
            end
        end
        push_entry.frame_flag = flag_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_time_reg  <= '0;
            synced_reg     <= 1'b0;
            count_reg      <= '0;
            flag_reg       <= 1'b0;
            frame_pend_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                prev_time_reg <= edge_time_lo;
            end
            synced_reg     <= synced_next;
            count_reg      <= count_next;
            flag_reg       <= flag_next;
            frame_pend_reg <= frame_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_wr)
        begin
            store_reg[count_reg] <= gap;
        end
    end

endmodule

@@ sv/ppmfd_back.sv @@
// ----------------------------------------------------------------------------
// PPM frame decoder back
// Pop classified words, drive the output register, sweep out full frames.
// ----------------------------------------------------------------------------
module ppmfd_back #(
    parameter int NUM_CHANNELS = ppmfd_pkg::NUM_CHANNELS_DEF,
    parameter int IDX_W        = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ppmfd_pkg::q_status_t q_stat,
    input  ppmfd_pkg::q_entry_t  pop_entry,
    output logic                 pop,
    output logic [IDX_W-1:0]     rd_idx,
    input  logic [15:0]          rd_data,
    output logic                 frame_done,
    output logic                 out_valid,
    input  logic                 out_ready,
    output ppmfd_pkg::q_entry_t  out_entry,
    output logic                 out_last
);

    logic                out_valid_reg, out_valid_next;
    ppmfd_pkg::q_entry_t out_entry_reg, out_entry_next;
    logic                out_last_reg, out_last_next;
    logic                frame_act_reg, frame_act_next;
    logic [IDX_W-1:0]    k_reg, k_next;
    logic                frame_flag_reg, frame_flag_next;
    logic                out_free;
    logic                k_last;

    assign out_free  = !out_valid_reg || out_ready;
    assign k_last    = (k_reg == IDX_W'(NUM_CHANNELS - 1));
    assign rd_idx    = k_reg;
    assign out_valid = out_valid_reg;
    assign out_entry = out_entry_reg;
    assign out_last  = out_last_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_entry_next  = out_entry_reg;
        out_last_next   = out_last_reg;
        frame_act_next  = frame_act_reg;
        k_next          = k_reg;
        frame_flag_next = frame_flag_reg;
        pop             = 1'b0;
        frame_done      = 1'b0;
        priority if (frame_act_reg && out_free)
        begin
            out_valid_next                = 1'b1;
            out_entry_next.status         = ppmfd_pkg::ST_FRAME_CH;
            out_entry_next.channel_index  = 3'(k_reg);
            out_entry_next.pulse_width_us = rd_data;
            out_entry_next.frame_flag     = frame_flag_reg;
            out_last_next                 = k_last;
            if (k_last)
            begin
                frame_act_next = 1'b0;
                frame_done     = 1'b1;
                k_next         = '0;
            end
            else
            begin
                k_next = k_reg + 1'b1;
            end
        end
        else if (!frame_act_reg && !q_stat.empty && out_free)
        begin
            pop = 1'b1;
            if (pop_entry.status == ppmfd_pkg::ST_FRAME_CH)
            begin
                frame_act_next  = 1'b1;
                k_next          = '0;
                frame_flag_next = pop_entry.frame_flag;
                out_valid_next  = 1'b0;
            end
            else
            begin
                out_valid_next = 1'b1;
                out_entry_next = pop_entry;
                out_last_next  = 1'b1;
            end
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            frame_act_reg <= 1'b0;
            k_reg         <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            frame_act_reg <= frame_act_next;
            k_reg         <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_entry_reg  <= out_entry_next;
        out_last_reg   <= out_last_next;
        frame_flag_reg <= frame_flag_next;
    end

endmodule

@@ sv/ppm_frame_decoder.sv @@
// ----------------------------------------------------------------------------
// PPM frame decoder
// Turns rising-edge timestamps of a PPM pulse train into channel results.
//
// Input stream: one word per rising edge, s_tdata = 32-bit microsecond time.
// Output stream: one word per result; tlast marks the final result of an edge,
// tuser carries the update flag. APB registers: sync gap minimum, pulse
// window minimum and maximum (byte addresses 0, 4, 8).
// A single result passes through the command queue into the output register;
// the words of a frame are read from the channel store after its queued word.
// Throughput: one edge per cycle for edges that give a single result, while
// the four-word command queue has room. An edge that completes a frame holds
// s_tready low until the back has loaded the last of its NUM_CHANNELS words
// into the output register, one channel per cycle read from the channel
// store while the output register is free.
// Reset clears sync, channel count, update flag, previous edge time, queue
// and output valid flag; registers return to 2200, 900 and 2100.
// A stalled receiver holds the output word; the queue keeps taking edges
// until it fills, then s_tready drops.
// ----------------------------------------------------------------------------
module ppm_frame_decoder #(
    parameter int NUM_CHANNELS = ppmfd_pkg::NUM_CHANNELS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // [31:0] edge_time_us
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // [2:0] status, [5:3] channel_index,
                                    // [21:6] pulse_width_us, [23:22] zero
    output logic        m_tuser,    // [0] frame_flag
    output logic        m_tlast
);

    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    ppmfd_pkg::cfg_t      cfg_reg;
    ppmfd_pkg::reg_idx_t  reg_sel;
    ppmfd_pkg::q_entry_t  push_entry;
    ppmfd_pkg::q_entry_t  pop_entry;
    ppmfd_pkg::q_entry_t  out_entry;
    ppmfd_pkg::q_status_t q_stat;
    logic                 push;
    logic                 pop;
    logic                 frame_done;
    logic [IDX_W-1:0]     rd_idx;
    logic [15:0]          rd_data;
    logic                 cfg_wr;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_sel = ppmfd_pkg::reg_idx_t'(paddr[3:2]);

    always_comb
    begin
        unique case (reg_sel)
            ppmfd_pkg::REG_SYNC_GAP_MIN: prdata = 32'(cfg_reg.sync_gap_min);
            ppmfd_pkg::REG_PULSE_MIN:    prdata = 32'(cfg_reg.pulse_min);
            ppmfd_pkg::REG_PULSE_MAX:    prdata = 32'(cfg_reg.pulse_max);
            default:                     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_gap_min <= ppmfd_pkg::SYNC_GAP_MIN_RST;
            cfg_reg.pulse_min    <= ppmfd_pkg::PULSE_MIN_RST;
            cfg_reg.pulse_max    <= ppmfd_pkg::PULSE_MAX_RST;
        end
        else if (cfg_wr)
        begin
            unique case (reg_sel)
                ppmfd_pkg::REG_SYNC_GAP_MIN: cfg_reg.sync_gap_min <= pwdata[15:0];
                ppmfd_pkg::REG_PULSE_MIN:    cfg_reg.pulse_min    <= pwdata[15:0];
                ppmfd_pkg::REG_PULSE_MAX:    cfg_reg.pulse_max    <= pwdata[15:0];
                default:                     cfg_reg              <= cfg_reg;
            endcase
        end
    end

    ppmfd_front #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .IDX_W        (IDX_W)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .edge_time_lo (s_tdata[15:0]),
        .push         (push),
        .push_entry   (push_entry),
        .q_stat       (q_stat),
        .frame_done   (frame_done),
        .rd_idx       (rd_idx),
        .rd_data      (rd_data)
    );

    ppmfd_queue #(
        .DEPTH      (ppmfd_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .stat       (q_stat)
    );

    ppmfd_back #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .IDX_W        (IDX_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_stat     (q_stat),
        .pop_entry  (pop_entry),
        .pop        (pop),
        .rd_idx     (rd_idx),
        .rd_data    (rd_data),
        .frame_done (frame_done),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_entry  (out_entry),
        .out_last   (m_tlast)
    );

    assign m_tdata = {2'b00, out_entry.pulse_width_us, out_entry.channel_index,
                      out_entry.status};
    assign m_tuser = out_entry.frame_flag;

endmodule

@@ sv/ppmfd_checker.sv @@
// ----------------------------------------------------------------------------
// PPM frame decoder checker
// Port-level assertions on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module ppmfd_checker #(
    parameter int NUM_CHANNELS = ppmfd_pkg::NUM_CHANNELS_DEF
) (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tlast
);

    localparam logic [2:0] LAST_IDX = 3'(NUM_CHANNELS - 1);

    logic is_frame_ch;
    logic is_stored;

    assign is_frame_ch = (m_tdata[2:0] == 3'(ppmfd_pkg::ST_FRAME_CH));
    assign is_stored   = (m_tdata[2:0] == 3'(ppmfd_pkg::ST_STORED));

    a_reset_idle: assert property (@(posedge clk)
        $rose(rst_n) |-> !m_tvalid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result word changed");

    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !is_frame_ch |-> m_tlast)
        else $error("single result without tlast");

    a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && is_frame_ch && m_tlast |-> m_tdata[5:3] == LAST_IDX)
        else $error("frame ends at wrong channel");

    a_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !is_frame_ch && !is_stored |-> m_tdata[5:3] == 3'd0)
        else $error("channel index set on non-channel result");

endmodule

bind ppm_frame_decoder ppmfd_checker #(
    .NUM_CHANNELS (NUM_CHANNELS)
) u_ppmfd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

@@ sim/ppm_frame_decoder_checker.sv @@
// ----------------------------------------------------------------------------
// PPM frame decoder checker
// Watches the register port and both streams, keeps its own decoder state,
// predicts the words that each accepted edge should produce and compares
// every output word with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module ppm_frame_decoder_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    input  logic        m_tuser,
    input  logic        m_tlast,
    output int          outstanding,
    output int          mismatches
);

    localparam int NCH = ppmfd_pkg::NUM_CHANNELS_DEF;

    typedef struct packed {
        ppmfd_pkg::status_t status;
        logic [2:0]         chan;
        logic [15:0]        width;
        logic               flag;
        logic               last;
    } decoded_word_t;

    logic [15:0]   sync_min;
    logic [15:0]   win_lo;
    logic [15:0]   win_hi;
    logic [31:0]   prev_time;
    logic          locked;
    logic [3:0]    chan_fill;
    logic [15:0]   chan_vals [NCH];
    logic          upd_flag;
    decoded_word_t pending_words [$];
    int            err_count;

    function automatic void queue_word(ppmfd_pkg::status_t st, logic [2:0] ch,
                                       logic [15:0] w, logic lst);
        decoded_word_t d;
        d.status = st;
        d.chan   = ch;
        d.width  = w;
        d.flag   = upd_flag;
        d.last   = lst;
        pending_words.push_back(d);
    endfunction

    function automatic void decode_edge(logic [31:0] t);
        logic [15:0] gap;
        gap       = 16'(t - prev_time);
        prev_time = t;
        if (!locked)
        begin
            if (gap >= sync_min)
            begin
                locked    = 1'b1;
                chan_fill = '0;
                upd_flag  = 1'b0;
                queue_word(ppmfd_pkg::ST_ACQUIRED, 3'd0, gap, 1'b1);
            end
            else
            begin
                queue_word(ppmfd_pkg::ST_WAITING, 3'd0, gap, 1'b1);
            end
        end
        else if (gap >= sync_min)
        begin
            chan_fill = '0;
            upd_flag  = 1'b1;
            queue_word(ppmfd_pkg::ST_FRAME_SYNC, 3'd0, gap, 1'b1);
        end
        else if (gap >= win_lo && gap <= win_hi)
        begin
            chan_vals[chan_fill[2:0]] = gap;
            if (int'(chan_fill) == NCH - 1)
            begin
                chan_fill = '0;
                for (int k = 0; k < NCH; k++)
                    queue_word(ppmfd_pkg::ST_FRAME_CH, 3'(k), chan_vals[k], k == NCH - 1);
            end
            else
            begin
                queue_word(ppmfd_pkg::ST_STORED, chan_fill[2:0], gap, 1'b1);
                chan_fill = chan_fill + 4'd1;
            end
        end
        else
        begin
            locked = 1'b0;
            queue_word(ppmfd_pkg::ST_LOST, 3'd0, gap, 1'b1);
        end
    endfunction

    function automatic void check_word();
        decoded_word_t want;
        if (pending_words.size() == 0)
        begin
            err_count++;
            if (err_count <= 10)
                $display("unexpected word: status %0d ch %0d width %0d flag %0b last %0b",
                         m_tdata[2:0], m_tdata[5:3], m_tdata[21:6], m_tuser, m_tlast);
        end
        else
        begin
            want = pending_words.pop_front();
            if (m_tdata[2:0] != want.status || m_tdata[5:3] != want.chan ||
                m_tdata[21:6] != want.width || m_tuser != want.flag ||
                m_tlast != want.last)
            begin
                err_count++;
                if (err_count <= 10)
                    $display("word mismatch: expected %0d/%0d/%0d/%0b/%0b got %0d/%0d/%0d/%0b/%0b",
                             want.status, want.chan, want.width, want.flag, want.last,
                             m_tdata[2:0], m_tdata[5:3], m_tdata[21:6], m_tuser,
                             m_tlast);
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_min    = ppmfd_pkg::SYNC_GAP_MIN_RST;
            win_lo      = ppmfd_pkg::PULSE_MIN_RST;
            win_hi      = ppmfd_pkg::PULSE_MAX_RST;
            prev_time   = '0;
            locked      = 1'b0;
            chan_fill   = '0;
            upd_flag    = 1'b0;
            err_count   = 0;
            pending_words.delete();
            outstanding <= 0;
            mismatches  <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    ppmfd_pkg::REG_SYNC_GAP_MIN: sync_min = pwdata[15:0];
                    ppmfd_pkg::REG_PULSE_MIN:    win_lo   = pwdata[15:0];
                    ppmfd_pkg::REG_PULSE_MAX:    win_hi   = pwdata[15:0];
                    default:                     ;
                endcase
            end
            if (m_tvalid && m_tready)
                check_word();
            if (s_tvalid && s_tready)
                decode_edge(s_tdata);
            outstanding <= pending_words.size();
            mismatches  <= err_count;
        end
    end

endmodule

@@ sim/ppm_frame_decoder_test.sv @@
// ----------------------------------------------------------------------------
// PPM frame decoder testbench
// Drives edge timestamps through the decoder under several register settings
// and idle patterns: a short directed sequence, then frames, some cut short,
// with random content amid noise edges. A checker beside the block predicts
// and compares every output word; this module makes stimulus and the verdict.
// ----------------------------------------------------------------------------
module ppm_frame_decoder_test;

    localparam int         STALL_LIMIT  = 3000;
    localparam int         HOLD_CYCLES  = 400;
    localparam int         PHASE_ITEMS  = 77;
    localparam int         NCH          = ppmfd_pkg::NUM_CHANNELS_DEF;
    localparam logic [1:0] UNMAPPED_IDX = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    int          outstanding;
    int          mismatches;
    int          tx_idle_pct    = 8;
    int          rx_idle_pct    = 48;
    logic        long_hold_req  = 1'b0;
    logic        long_hold_done = 1'b0;
    logic [31:0] edge_clock;
    logic [15:0] cfg_sync;
    logic [15:0] cfg_lo;
    logic [15:0] cfg_hi;

    ppm_frame_decoder u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    ppm_frame_decoder_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .outstanding (outstanding),
        .mismatches  (mismatches)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold_req && !long_hold_done)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                long_hold_done = 1'b1;
            end
            m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT)
            begin
                $display("ppm_frame_decoder_test failed");
                $finish;
            end
        end
    end

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
    endtask

    task automatic set_config(input logic [15:0] sync, input logic [15:0] lo,
                              input logic [15:0] hi);
        apb_write(ppmfd_pkg::REG_SYNC_GAP_MIN, {16'd0, sync});
        apb_write(ppmfd_pkg::REG_PULSE_MIN, {16'd0, lo});
        apb_write(ppmfd_pkg::REG_PULSE_MAX, {16'd0, hi});
        apb_write(UNMAPPED_IDX, $urandom);
        psel     <= 1'b0;
        penable  <= 1'b0;
        cfg_sync = sync;
        cfg_lo   = lo;
        cfg_hi   = hi;
    endtask

    task automatic push_edge(input logic [31:0] t);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= t;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        edge_clock = t;
    endtask

    task automatic push_gap(input logic [31:0] g);
        push_edge(edge_clock + g);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    task automatic random_phase(input int n_items);
        int          sent;
        int          pick;
        int          n_ch;
        logic [31:0] g;
        sent = 0;
        while (sent < n_items)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 75)
            begin
                g = $urandom_range(cfg_sync, 16'hFFFF);
                if ($urandom_range(0, 7) == 0)
                    g = g + 32'h0001_0000 * $urandom_range(1, 3);
                push_gap(g);
                n_ch = ($urandom_range(0, 3) == 0) ? $urandom_range(0, NCH) : NCH;
                for (int k = 0; k < n_ch; k++)
                    push_gap($urandom_range(cfg_lo, cfg_hi));
                sent += n_ch + 1;
            end
            else if (pick < 90)
            begin
                push_gap($urandom_range(0, 16'hFFFF));
                sent++;
            end
            else if (pick < 95)
            begin
                push_gap($urandom);
                sent++;
            end
            else
            begin
                push_edge($urandom);
                sent++;
            end
        end
    endtask

    initial
    begin
        rst_n      <= 1'b0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        s_tvalid   <= 1'b0;
        s_tdata    <= '0;
        edge_clock = '0;
        cfg_sync   = ppmfd_pkg::SYNC_GAP_MIN_RST;
        cfg_lo     = ppmfd_pkg::PULSE_MIN_RST;
        cfg_hi     = ppmfd_pkg::PULSE_MAX_RST;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        push_gap(100);
        push_gap(2200);
        push_gap(900);
        push_gap(2100);
        push_gap(1000);
        push_gap(1200);
        push_gap(1400);
        push_gap(1600);
        push_gap(1800);
        push_gap(2000);
        push_gap(2200);
        push_gap(899);
        push_gap(0);
        push_gap(65535);
        push_gap(2101);
        push_edge(32'hFFFF_FF00);
        push_edge(32'h0000_0900);
        push_gap(32'h0001_0000 + 1000);

        for (int ph = 1; ph <= 6; ph++)
        begin
            drain_results();
            case (ph)
                1: set_config(ppmfd_pkg::SYNC_GAP_MIN_RST, ppmfd_pkg::PULSE_MIN_RST,
                              ppmfd_pkg::PULSE_MAX_RST);
                2: set_config(16'd1500, 16'd900, 16'd2100);
                3: set_config(16'hFFFF, 16'd0, 16'hFFFF);
                4: set_config(16'd3000, 16'd2000, 16'd1000);
                5: set_config(16'd0, 16'd900, 16'd2100);
                default: set_config(ppmfd_pkg::SYNC_GAP_MIN_RST, ppmfd_pkg::PULSE_MIN_RST,
                                    ppmfd_pkg::PULSE_MAX_RST);
            endcase
            tx_idle_pct   = (ph <= 2) ? 8 : ((ph <= 4) ? 48 : 0);
            rx_idle_pct   = (ph <= 2) ? 48 : ((ph <= 4) ? 8 : 0);
            long_hold_req = (ph == 1);
            random_phase(PHASE_ITEMS);
        end

        drain_results();
        repeat (NCH + 4) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("ppm_frame_decoder_test passed");
        else
            $display("ppm_frame_decoder_test failed");
        $finish;
    end

endmodule

@@ ppm_frame_decoder.f @@
sv/ppmfd_pkg.sv
sv/ppmfd_queue.sv
sv/ppmfd_front.sv
sv/ppmfd_back.sv
sv/ppm_frame_decoder.sv
sv/ppmfd_checker.sv
sim/ppm_frame_decoder_checker.sv
sim/ppm_frame_decoder_test.sv
